/* hw/rtl/cpa_pkg.sv */
package cpa_pkg;

   // store geometry and the usable id window
   localparam int ID_W        = 6;
   localparam int DEPTH       = 1 << ID_W;
   localparam int COLOR_W     = 8;
   localparam int KEY_W       = 2 * COLOR_W;
   localparam int FIRST_ID    = 16;
   localparam int ID_LIMIT    = 64;
   localparam int USABLE_END  = (ID_LIMIT > DEPTH) ? DEPTH : ID_LIMIT;
   localparam bit RANGE_EMPTY = (FIRST_ID >= USABLE_END);
   localparam int LAST_ID     = RANGE_EMPTY ? FIRST_ID : USABLE_END - 1;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_BADID = 2'd2
   } status_type;

endpackage

/* hw/rtl/color_pair_id_allocator.sv */
// Colour pair id allocator. A request is taken when start is high and busy is
// low, and every request gives exactly one result: rsp_valid is high for one
// cycle with rsp_result_id, rsp_result_color and rsp_status, and the receiver
// must take it then, since the block cannot hold it. Free, clear and a query
// for an unusable or unused id answer on the cycle after the request; a valid
// query answers by way of S_QWAIT. An allocate walks the pair store one entry
// a cycle through its single read port over the ids FIRST_ID up to the usable
// end (16 to 63 by default), then S_LAST and S_DECIDE; busy stays high meanwhile.
// The in-use flags are cleared by reset at once; no clearing pass is needed.
module color_pair_id_allocator
   import cpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [COLOR_W-1:0] req_fore_color,
   input  logic [COLOR_W-1:0] req_back_color,
   input  logic [ID_W-1:0]    req_pair_id,
   output logic               rsp_valid,
   output logic [ID_W-1:0]    rsp_result_id,
   output logic [COLOR_W-1:0] rsp_result_color,
   output logic [1:0]         rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_DECIDE,
      S_QWAIT
   } state_type;

   state_type          state_ff, state_in;
   logic [DEPTH-1:0]   in_use_ff, in_use_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [ID_W-1:0]    scan_idx_ff, scan_idx_in;
   logic               match_found_ff, match_found_in;
   logic [ID_W-1:0]    match_id_ff, match_id_in;
   logic               free_found_ff, free_found_in;
   logic [ID_W-1:0]    free_id_ff, free_id_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ID_W-1:0]    rd_idx_ff, rd_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   status_type         rsp_status_ff, rsp_status_in;

   // pair store: one read and one write port
   logic [KEY_W-1:0]   pair_mem [DEPTH];
   logic [KEY_W-1:0]   rd_data_ff;
   logic [ID_W-1:0]    rd_addr;
   logic               wr_en;

   logic               accept;
   logic               req_usable;

   assign accept     = start && (state_ff == S_IDLE);
   assign req_usable = (int'(req_pair_id) >= FIRST_ID) && (int'(req_pair_id) < USABLE_END);
   assign rd_addr    = (state_ff == S_IDLE) ? req_pair_id : scan_idx_ff;
   assign wr_en      = (state_ff == S_DECIDE) && !match_found_ff && free_found_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_mem[free_id_ff] <= key_ff;
      end
      rd_data_ff <= pair_mem[rd_addr];
   end

   // sequencer: next state, flags and result
   always_comb begin
      state_in       = state_ff;
      in_use_in      = in_use_ff;
      key_in         = key_ff;
      scan_idx_in    = scan_idx_ff;
      match_found_in = match_found_ff;
      match_id_in    = match_id_ff;
      free_found_in  = free_found_ff;
      free_id_in     = free_id_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = scan_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_id_in      = '0;
      rsp_color_in   = '0;
      rsp_status_in  = ST_OK;

      // compare the entry read last cycle against the key
      if (rd_vld_ff && in_use_ff[rd_idx_ff] && (rd_data_ff == key_ff) && !match_found_ff) begin
         match_found_in = 1'b1;
         match_id_in    = rd_idx_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (kind_type'(req_kind))
                  KIND_ALLOC: begin
                     key_in         = {req_fore_color, req_back_color};
                     match_found_in = 1'b0;
                     free_found_in  = 1'b0;
                     if (RANGE_EMPTY) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        scan_idx_in = ID_W'(FIRST_ID);
                        state_in    = S_SCAN;
                     end
                  end
                  KIND_FREE: begin
                     rsp_valid_in = 1'b1;
                     if ((req_pair_id != '0) && req_usable && in_use_ff[req_pair_id]) begin
                        in_use_in[req_pair_id] = 1'b0;
                     end else begin
                        rsp_status_in = ST_BADID;
                     end
                  end
                  KIND_QUERY: begin
                     if (req_usable && in_use_ff[req_pair_id]) begin
                        state_in = S_QWAIT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BADID;
                     end
                  end
                  KIND_CLEAR: begin
                     in_use_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // issue one read a cycle; note the lowest free id on the way
            rd_vld_in = 1'b1;
            rd_idx_in = scan_idx_ff;
            if (!in_use_ff[scan_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_id_in    = scan_idx_ff;
            end
            if (scan_idx_ff == ID_W'(LAST_ID)) begin
               state_in = S_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_LAST: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (match_found_ff) begin
               rsp_id_in = match_id_ff;
            end else if (free_found_ff) begin
               in_use_in[free_id_ff] = 1'b1;
               rsp_id_in             = free_id_ff;
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         S_QWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_color_in = rd_data_ff[COLOR_W-1:0];
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state, flags and the registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         in_use_ff      <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         in_use_ff      <= in_use_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_ff        <= key_in;
      scan_idx_ff   <= scan_idx_in;
      match_id_ff   <= match_id_in;
      free_id_ff    <= free_id_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_result_color = rsp_color_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* hw/rtl/cpa_checker.sv */
module cpa_checker
   import cpa_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [ID_W-1:0]    rsp_result_id,
   input logic [COLOR_W-1:0] rsp_result_color,
   input logic [1:0]         rsp_status
);

   // every transfer in either goes busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request neither started work nor answered");

   // leaving busy always comes with a result
   a_done_answers: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // a result is shown only while idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // full carries no id and no colour
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |->
         ((rsp_result_id == '0) && (rsp_result_color == '0)))
      else $error("full result carries data");

   // an id and a colour never come together
   a_id_or_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_id != '0)) |-> (rsp_result_color == '0))
      else $error("id and colour both set");

endmodule

bind color_pair_id_allocator cpa_checker u_cpa_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_result_id    (rsp_result_id),
   .rsp_result_color (rsp_result_color),
   .rsp_status       (rsp_status)
);
